// ===== rtl/core/eor_pkg.sv =====
`timescale 1ns / 1ps

package eor_pkg;

    // Serial multiplier operand width and serial divider widths.
    localparam int MUL_W = 32;
    localparam int DIV_N = 36;
    localparam int DIV_D = 24;

    localparam int BLOCK_SIZE_DEF = 64;

    // e in Q2.30.
    localparam logic [31:0] E_Q30 = 32'hADF8_5459;
    localparam logic [17:0] BLOCKS_MAX = 18'h3_FFFF;

    localparam logic [15:0] OVERSHOOT_RST = 16'd6554;
    localparam logic [7:0] SPMS_RST = 8'd48;

    // Request codes.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_TARGET = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_OVERSHOOT = 2'd0;
    localparam logic [1:0] REG_SPMS = 2'd1;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [2*MUL_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] num;
        logic [DIV_D-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quot;
    } div_rsp_t;

endpackage

// ===== rtl/core/exponential_overshoot_ramp_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                                           Beat
// input     in         s_valid s_ready s_req_type s_target_value s_ramp_ms  one request
// result    out        m_valid m_ready m_sample m_ramping               one envelope sample
// config    in         cfg_valid cfg_ready cfg_index cfg_data           one register write
//
// A new-target or stop request is handled in idle. A tick outside a ramp, or an armed tick in
// mid-block, goes straight to the final state. A ramping tick runs two passes of the bit-serial
// multiplier, then presents the beat from the final state and returns to idle.
// A tick that starts an armed ramp runs five multiplier passes and up to two divider passes
// to compute the block count, coefficient and first value.
// Reset is synchronous and active low; it clears the control and envelope state and sets the
// configuration to its defaults. A result that the sink stalls holds the block in its final
// state; requests are taken only while the sequencer is idle.
module exponential_overshoot_ramp_top #(
    parameter int BLOCK_SIZE = eor_pkg::BLOCK_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic signed [23:0] s_target_value,
    input  logic [15:0] s_ramp_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [23:0] m_sample,
    output logic        m_ramping,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PosW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam logic [PosW-1:0] PosLast = PosW'(BLOCK_SIZE - 1);

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DMUL  = 9'b000000010,
        ST_NBDIV = 9'b000000100,
        ST_UMUL  = 9'b000001000,
        ST_PMUL  = 9'b000010000,
        ST_QDIV  = 9'b000100000,
        ST_SMUL  = 9'b001000000,
        ST_MMUL  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [15:0] overshoot_reg;
    logic [7:0]  spms_reg;

    logic signed [23:0] current_reg;
    logic signed [23:0] target_reg;
    logic signed [23:0] start_reg;
    logic signed [24:0] span_reg;
    logic [31:0]        scale_reg;
    logic [31:0]        coef_reg;
    logic [17:0]        blocks_reg;
    logic               retarget_reg;
    logic [15:0]        pend_ms_reg;
    logic [PosW-1:0]    pos_reg;
    logic [23:0]        d_reg;
    logic               dec_reg;

    logic signed [23:0] res_sample_reg;
    logic               res_ramp_reg;
    logic               m_valid_reg;
    logic signed [23:0] m_sample_reg;
    logic               m_ramping_reg;

    eor_pkg::mul_req_t mul_req;
    eor_pkg::mul_rsp_t mul_rsp;
    eor_pkg::div_req_t div_req;
    eor_pkg::div_rsp_t div_rsp;

    logic        accept;
    logic        ramp_active;
    logic        arm;
    logic        out_free;
    logic [31:0] over_target;
    logic        dir_up;
    logic [31:0] scale_diff;
    logic [31:0] step;
    logic [31:0] scale_new;
    logic [31:0] coef_sat;
    logic [17:0] nb_clamped;
    logic [24:0] span_abs;
    logic signed [28:0] mag;
    logic signed [28:0] g_raw;
    logic signed [28:0] g_clamped;
    logic signed [23:0] g_sat;

    eor_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    eor_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign ramp_active = retarget_reg || (blocks_reg != 18'd0);
    assign arm       = (pos_reg == '0) && retarget_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Scale step toward 1+overshoot.
    assign over_target = 32'h4000_0000 + {2'b00, overshoot_reg, 14'd0};
    assign dir_up      = (over_target >= scale_reg);
    assign scale_diff  = dir_up ? (over_target - scale_reg) : (scale_reg - over_target);
    assign step        = mul_rsp.prod[63:32];
    assign scale_new   = dir_up ? (scale_reg + step) : (scale_reg - step);

    // Coefficient saturates to all ones when the quotient exceeds 32 bits.
    assign coef_sat = (div_rsp.quot[35:32] != 4'd0) ? 32'hFFFF_FFFF : div_rsp.quot[31:0];

    // Block count: at least one, at most the counter's range.
    always_comb begin
        if (div_rsp.quot == '0) begin
            nb_clamped = 18'd1;
        end else if (div_rsp.quot > {18'd0, eor_pkg::BLOCKS_MAX}) begin
            nb_clamped = eor_pkg::BLOCKS_MAX;
        end else begin
            nb_clamped = div_rsp.quot[17:0];
        end
    end

    // Value: start plus the truncated span-scale product, clamped at the target in the
    // direction of the ramp, then saturated to the sample range.
    assign span_abs = span_reg[24] ? (25'd0 - span_reg) : span_reg;
    assign mag      = {2'b00, mul_rsp.prod[56:30]};
    assign g_raw    = span_reg[24] ? (29'(start_reg) - mag) : (29'(start_reg) + mag);

    always_comb begin
        g_clamped = g_raw;
        if (!span_reg[24] && (g_raw > 29'(target_reg))) begin
            g_clamped = 29'(target_reg);
        end else if (span_reg[24] && (g_raw < 29'(target_reg))) begin
            g_clamped = 29'(target_reg);
        end
        if (g_clamped > 29'sd8388607) begin
            g_sat = 24'sh7F_FFFF;
        end else if (g_clamped < -29'sd8388608) begin
            g_sat = 24'sh80_0000;
        end else begin
            g_sat = g_clamped[23:0];
        end
    end

    // Sequencer and the operands of each serial unit pass.
    always_comb begin
        state_next = state_reg;
        mul_req    = '0;
        div_req    = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_req_type == eor_pkg::REQ_TICK)) begin
                    if (arm) begin
                        state_next    = ST_DMUL;
                        mul_req.start = 1'b1;
                        mul_req.a     = 32'(pend_ms_reg);
                        mul_req.b     = 32'(spms_reg);
                    end else if (!retarget_reg && (blocks_reg != 18'd0)) begin
                        state_next    = ST_SMUL;
                        mul_req.start = 1'b1;
                        mul_req.a     = coef_reg;
                        mul_req.b     = scale_diff;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DMUL: begin
                if (mul_rsp.done) begin
                    state_next    = ST_NBDIV;
                    div_req.start = 1'b1;
                    div_req.num   = 36'(mul_rsp.prod[23:0]);
                    div_req.den   = eor_pkg::DIV_D'(BLOCK_SIZE);
                end
            end
            ST_NBDIV: begin
                if (div_rsp.done) begin
                    state_next    = ST_UMUL;
                    mul_req.start = 1'b1;
                    mul_req.a     = 32'({1'b1, overshoot_reg});
                    mul_req.b     = 32'({1'b1, overshoot_reg});
                end
            end
            ST_UMUL: begin
                if (mul_rsp.done) begin
                    state_next    = ST_PMUL;
                    mul_req.start = 1'b1;
                    mul_req.a     = eor_pkg::E_Q30;
                    mul_req.b     = mul_rsp.prod[33:2];
                end
            end
            ST_PMUL: begin
                if (mul_rsp.done) begin
                    if (d_reg == 24'd0) begin
                        state_next    = ST_SMUL;
                        mul_req.start = 1'b1;
                        mul_req.a     = 32'hFFFF_FFFF;
                        mul_req.b     = scale_diff;
                    end else begin
                        state_next    = ST_QDIV;
                        div_req.start = 1'b1;
                        div_req.num   = {mul_rsp.prod[63:30], 2'b00};
                        div_req.den   = d_reg;
                    end
                end
            end
            ST_QDIV: begin
                if (div_rsp.done) begin
                    state_next    = ST_SMUL;
                    mul_req.start = 1'b1;
                    mul_req.a     = coef_sat;
                    mul_req.b     = scale_diff;
                end
            end
            ST_SMUL: begin
                if (mul_rsp.done) begin
                    state_next    = ST_MMUL;
                    mul_req.start = 1'b1;
                    mul_req.a     = 32'(span_abs);
                    mul_req.b     = scale_new;
                end
            end
            ST_MMUL: begin
                if (mul_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            overshoot_reg <= eor_pkg::OVERSHOOT_RST;
            spms_reg      <= eor_pkg::SPMS_RST;
            current_reg   <= '0;
            target_reg    <= '0;
            start_reg     <= '0;
            span_reg      <= '0;
            scale_reg     <= '0;
            coef_reg      <= '0;
            blocks_reg    <= '0;
            retarget_reg  <= 1'b0;
            pend_ms_reg   <= '0;
            pos_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    eor_pkg::REG_OVERSHOOT: overshoot_reg <= cfg_data;
                    eor_pkg::REG_SPMS:      spms_reg <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end

            // A new beat is raised only once the previous one has left.
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_req_type)
                            eor_pkg::REQ_TARGET: begin
                                target_reg <= s_target_value;
                                scale_reg  <= '0;
                                if (s_ramp_ms == 16'd0) begin
                                    current_reg  <= s_target_value;
                                    blocks_reg   <= '0;
                                    retarget_reg <= 1'b0;
                                end else begin
                                    start_reg    <= current_reg;
                                    span_reg     <= 25'(s_target_value) - 25'(current_reg);
                                    retarget_reg <= 1'b1;
                                    pend_ms_reg  <= s_ramp_ms;
                                end
                            end
                            eor_pkg::REQ_STOP: begin
                                target_reg   <= current_reg;
                                blocks_reg   <= '0;
                                retarget_reg <= 1'b0;
                                scale_reg    <= '0;
                            end
                            eor_pkg::REQ_TICK: begin
                                if (!ramp_active) begin
                                    current_reg <= target_reg;
                                end
                                if (!retarget_reg && (blocks_reg != 18'd0)
                                        && (pos_reg == PosLast)) begin
                                    blocks_reg <= blocks_reg - 1'b1;
                                end
                                pos_reg <= (pos_reg == PosLast) ? '0 : (pos_reg + 1'b1);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_NBDIV: begin
                    if (div_rsp.done) begin
                        blocks_reg <= nb_clamped - 18'(dec_reg);
                    end
                end
                ST_PMUL: begin
                    if (mul_rsp.done && (d_reg == 24'd0)) begin
                        coef_reg     <= 32'hFFFF_FFFF;
                        retarget_reg <= 1'b0;
                    end
                end
                ST_QDIV: begin
                    if (div_rsp.done) begin
                        coef_reg     <= coef_sat;
                        retarget_reg <= 1'b0;
                    end
                end
                ST_SMUL: begin
                    if (mul_rsp.done) begin
                        scale_reg <= scale_new;
                    end
                end
                ST_MMUL: begin
                    if (mul_rsp.done) begin
                        current_reg <= g_sat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept && (s_req_type == eor_pkg::REQ_TICK)) begin
            res_sample_reg <= ramp_active ? current_reg : target_reg;
            res_ramp_reg   <= ramp_active;
            dec_reg        <= (pos_reg == PosLast);
        end
        if ((state_reg == ST_DMUL) && mul_rsp.done) begin
            d_reg <= mul_rsp.prod[23:0];
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_sample_reg  <= res_sample_reg;
            m_ramping_reg <= res_ramp_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;
    assign m_ramping = m_ramping_reg;

`ifndef SYNTHESIS
    // The multiplier finishes only while the sequencer waits on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == ST_DMUL || state_reg == ST_UMUL
            || state_reg == ST_PMUL || state_reg == ST_SMUL || state_reg == ST_MMUL))
        else $error("multiplier finished outside a multiply state");

    // The divider finishes only while the sequencer waits on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_NBDIV || state_reg == ST_QDIV))
        else $error("divider finished outside a divide state");

    // A new result beat comes only out of the final state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final state");
`endif

endmodule

// ===== rtl/core/eor_mul.sv =====
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle.
module eor_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  eor_pkg::mul_req_t req,
    output eor_pkg::mul_rsp_t rsp
);

    localparam int W = eor_pkg::MUL_W;
    localparam int CW = $clog2(W);

    logic [W-1:0]  a_reg;
    logic [W-1:0]  hi_reg;
    logic [W-1:0]  lo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    sum;
    logic          last;

    assign sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(W + 1){1'b0}});
    assign last = (cnt_reg == CW'(W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg  <= req.a;
            hi_reg <= '0;
            lo_reg <= req.b;
        end else if (busy_reg) begin
            hi_reg <= sum[W:1];
            lo_reg <= {sum[0], lo_reg[W-1:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = {hi_reg, lo_reg};

endmodule

// ===== rtl/core/eor_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module eor_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  eor_pkg::div_req_t req,
    output eor_pkg::div_rsp_t rsp
);

    localparam int N = eor_pkg::DIV_N;
    localparam int D = eor_pkg::DIV_D;
    localparam int CW = $clog2(N);

    logic [N-1:0]  num_reg;
    logic [D-1:0]  rem_reg;
    logic [D-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [D:0]    trial;
    logic [D:0]    diff;
    logic          ge;
    logic          last;

    assign trial = {rem_reg, num_reg[N-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};
    assign last  = (cnt_reg == CW'(N - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end else if (busy_reg) begin
            num_reg <= {num_reg[N-2:0], ge};
            rem_reg <= ge ? diff[D-1:0] : trial[D-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int BLOCK = eor_pkg::BLOCK_SIZE_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 420;
    localparam logic [1:0] REQ_NONE = 2'd3;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_req_type;
    logic signed [23:0] s_target_value;
    logic [15:0] s_ramp_ms;
    logic m_valid;
    logic m_ready;
    logic signed [23:0] m_sample;
    logic m_ramping;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    exponential_overshoot_ramp_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_target_value(s_target_value), .s_ramp_ms(s_ramp_ms),
        .m_valid(m_valid), .m_ready(m_ready), .m_sample(m_sample),
        .m_ramping(m_ramping),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // One expected output beat of the envelope.
    typedef struct {
        logic signed [23:0] sample;
        logic               ramping;
    } env_beat_t;

    // One row of the directed table. A row with has_exp set carries an expected
    // sample that is obvious by inspection, checked against the predictor too.
    typedef struct {
        logic [1:0]         req;
        logic signed [23:0] target;
        logic [15:0]        ms;
        bit                 has_exp;
        logic signed [23:0] exp_sample;
    } stim_row_t;

    env_beat_t expected_beats[$];
    int fail_count = 0;
    int ticks_sent = 0;
    int beats_seen = 0;
    int idle_cycles = 0;
    bit env_ramping_seen = 0;

    // Envelope predictor state, mirrored from the block's behavior.
    logic [15:0]        env_overshoot;
    logic [7:0]         env_spms;
    logic signed [23:0] env_value;
    logic signed [23:0] env_target;
    logic signed [23:0] env_start;
    logic signed [24:0] env_span;
    logic [31:0]        env_scale;
    logic [31:0]        env_coef;
    logic [17:0]        env_blocks;
    logic               env_armed;
    logic [15:0]        env_pend_ms;
    int                 env_pos;

    function automatic void env_reset();
        env_overshoot = eor_pkg::OVERSHOOT_RST;
        env_spms = eor_pkg::SPMS_RST;
        env_value = '0;
        env_target = '0;
        env_start = '0;
        env_span = '0;
        env_scale = '0;
        env_coef = '0;
        env_blocks = '0;
        env_armed = 1'b0;
        env_pend_ms = '0;
        env_pos = 0;
    endfunction

    // Latch block count and coefficient for an armed ramp at the boundary.
    function automatic void env_start_ramp();
        logic [63:0] nb;
        logic [63:0] u;
        logic [63:0] m;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] q;
        d = 64'(env_pend_ms) * 64'(env_spms);
        nb = d / BLOCK;
        u = 64'd65536 + 64'(env_overshoot);
        m = (u * u) >> 2;
        p = (64'(eor_pkg::E_Q30) * m) >> 30;
        if (nb == 0) nb = 1;
        if (nb > 64'(eor_pkg::BLOCKS_MAX)) nb = 64'(eor_pkg::BLOCKS_MAX);
        env_blocks = nb[17:0];
        if (d == 0) q = 64'hFFFF_FFFF;
        else q = (p << 2) / d;
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        env_coef = q[31:0];
        env_armed = 1'b0;
    endfunction

    // Move the scale one step toward 1+overshoot and recompute the value.
    function automatic void env_advance();
        logic [63:0] ot;
        logic [63:0] s;
        logic [63:0] mag;
        longint      g;
        ot = (64'd1 << 30) + (64'(env_overshoot) << 14);
        s = 64'(env_scale);
        if (ot >= s) s = s + ((64'(env_coef) * (ot - s)) >> 32);
        else s = s - ((64'(env_coef) * (s - ot)) >> 32);
        env_scale = s[31:0];
        s = 64'(env_scale);
        if (env_span >= 0) begin
            mag = (64'(unsigned'(env_span)) * s) >> 30;
            g = longint'(env_start) + longint'(mag);
            if (g > longint'(env_target)) g = env_target;
        end else begin
            mag = (64'(-longint'(env_span)) * s) >> 30;
            g = longint'(env_start) - longint'(mag);
            if (g < longint'(env_target)) g = env_target;
        end
        if (g > 8388607) g = 8388607;
        if (g < -8388608) g = -8388608;
        env_value = 24'(g);
    endfunction

    // Apply one accepted request; ticks push one expected beat.
    function automatic void env_apply(logic [1:0] req, logic signed [23:0] tgt,
                                      logic [15:0] ms);
        env_beat_t b;
        case (req)
            eor_pkg::REQ_TARGET: begin
                env_target = tgt;
                env_scale = '0;
                if (ms == 0) begin
                    env_value = tgt;
                    env_blocks = '0;
                    env_armed = 1'b0;
                end else begin
                    env_start = env_value;
                    env_span = 25'(tgt) - 25'(env_value);
                    env_armed = 1'b1;
                    env_pend_ms = ms;
                end
            end
            eor_pkg::REQ_STOP: begin
                env_target = env_value;
                env_blocks = '0;
                env_armed = 1'b0;
                env_scale = '0;
            end
            eor_pkg::REQ_TICK: begin
                if (env_pos == 0 && env_armed) env_start_ramp();
                if (env_armed) begin
                    b.sample = env_value;
                    b.ramping = 1'b1;
                end else if (env_blocks > 0) begin
                    b.sample = env_value;
                    b.ramping = 1'b1;
                    env_advance();
                    if (env_pos == BLOCK - 1) env_blocks = env_blocks - 1;
                end else begin
                    env_value = env_target;
                    b.sample = env_value;
                    b.ramping = 1'b0;
                end
                env_pos = (env_pos + 1) % BLOCK;
                expected_beats.push_back(b);
            end
            default: ;
        endcase
    endfunction

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: stalls follow a rotating mask, with quiet stretches in between.
    logic [15:0] stall_mask;
    int stall_phase;
    initial begin
        m_ready = 1'b0;
        stall_mask = 16'hA5C3;
        stall_phase = 0;
        forever begin
            @(negedge aclk);
            stall_phase++;
            if (stall_phase % 97 == 0) stall_mask = 16'($urandom);
            if ((stall_phase / 200) % 3 == 2) m_ready <= 1'b1;
            else m_ready <= stall_mask[stall_phase % 16];
        end
    end

    // Result checker and watchdog, both on the rising edge.
    always @(posedge aclk) begin
        env_beat_t e;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d beats outstanding",
                         expected_beats.size());
                $display("Simulation FAILED");
                $finish;
            end
            if (m_valid && m_ready) begin
                beats_seen++;
                if (expected_beats.size() == 0) begin
                    $error("Unexpected beat: sample %0d ramping %0b", m_sample, m_ramping);
                    fail_count++;
                end else begin
                    e = expected_beats.pop_front();
                    if (m_sample !== e.sample) begin
                        $error("sample: expected %0d, got %0d", e.sample, m_sample);
                        fail_count++;
                    end
                    if (m_ramping !== e.ramping) begin
                        $error("ramping: expected %0b, got %0b", e.ramping, m_ramping);
                        fail_count++;
                    end
                    if (m_ramping === 1'b1) env_ramping_seen = 1'b1;
                end
            end
        end
    end

    // Send one request; the predictor is updated at the accepting edge.
    task automatic send_req(logic [1:0] req, logic signed [23:0] tgt, logic [15:0] ms);
        s_valid <= 1'b1;
        s_req_type <= req;
        s_target_value <= tgt;
        s_ramp_ms <= ms;
        do @(posedge aclk); while (!s_ready);
        env_apply(req, tgt, ms);
        if (req == eor_pkg::REQ_TICK) ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic send_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait until every expected beat is back, then let the sequencer settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == eor_pkg::REG_OVERSHOOT) env_overshoot = val;
        else if (idx == eor_pkg::REG_SPMS) env_spms = val[7:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random request mix: mostly ticks, so ramps run through several blocks.
    task automatic send_random(bit short_ramps);
        logic [1:0] req;
        logic [15:0] ms;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 82) req = eor_pkg::REQ_TICK;
        else if (pick < 93) req = eor_pkg::REQ_TARGET;
        else if (pick < 97) req = eor_pkg::REQ_STOP;
        else req = REQ_NONE;
        case ($urandom_range(0, 5))
            0: ms = 16'd0;
            1: ms = 16'($urandom);
            default: ms = short_ramps ? 16'($urandom_range(1, 4)) : 16'($urandom_range(1, 40));
        endcase
        send_req(req, 24'($urandom), ms);
    endtask

    stim_row_t dir_table[$];
    env_beat_t peek;
    int burst;

    initial begin
        // Directed table; expected samples are typed in where trivially known.
        dir_table = '{
            '{eor_pkg::REQ_TICK,   24'sd0,        16'd0,     1, 24'sd0},
            '{eor_pkg::REQ_TARGET, 24'sh7FFFFF,   16'd0,     0, 24'sd0},
            '{eor_pkg::REQ_TICK,   24'sd0,        16'd0,     1, 24'sh7FFFFF},
            '{eor_pkg::REQ_TARGET, -24'sh800000,  16'd0,     0, 24'sd0},
            '{eor_pkg::REQ_TICK,   24'sd0,        16'd0,     1, -24'sh800000},
            '{REQ_NONE,            24'sh555555,   16'hFFFF,  0, 24'sd0},
            '{eor_pkg::REQ_TICK,   24'sd0,        16'd0,     1, -24'sh800000},
            '{eor_pkg::REQ_TARGET, 24'sh7FFFFF,   16'd1,     0, 24'sd0},
            '{eor_pkg::REQ_TICK,   24'sd0,        16'd0,     0, 24'sd0},
            '{eor_pkg::REQ_TICK,   24'sd0,        16'd0,     0, 24'sd0},
            '{eor_pkg::REQ_STOP,   24'sd0,        16'd0,     0, 24'sd0},
            '{eor_pkg::REQ_TICK,   24'sd0,        16'd0,     0, 24'sd0},
            '{eor_pkg::REQ_TARGET, -24'sh123456,  16'hFFFF,  0, 24'sd0},
            '{eor_pkg::REQ_TICK,   24'sd0,        16'd0,     0, 24'sd0},
            '{eor_pkg::REQ_STOP,   24'sh2AAAAA,   16'h5555,  0, 24'sd0},
            '{eor_pkg::REQ_TICK,   24'sd0,        16'd0,     0, 24'sd0},
            '{eor_pkg::REQ_TARGET, 24'sd0,        16'd0,     0, 24'sd0},
            '{eor_pkg::REQ_TICK,   24'sd0,        16'd0,     1, 24'sd0}
        };

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = eor_pkg::REQ_TICK;
        s_target_value = '0;
        s_ramp_ms = '0;
        cfg_valid = 1'b0;
        cfg_index = eor_pkg::REG_OVERSHOOT;
        cfg_data = '0;
        env_reset();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows go back to back so the armed mid-block case is hit.
        foreach (dir_table[i]) begin
            send_req(dir_table[i].req, dir_table[i].target, dir_table[i].ms);
            if (dir_table[i].has_exp) begin
                peek = expected_beats[$];
                if (peek.sample !== dir_table[i].exp_sample) begin
                    $error("table row %0d sample: expected %0d, predicted %0d",
                           i, dir_table[i].exp_sample, peek.sample);
                    fail_count++;
                end
            end
        end
        // Run a short ramp out past a block boundary to its end.
        send_req(eor_pkg::REQ_TARGET, 24'sh400000, 16'd2);
        repeat (3 * BLOCK) send_req(eor_pkg::REQ_TICK, '0, '0);
        drain();

        // Several register settings, extremes among them; each phase ends drained.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(eor_pkg::REG_OVERSHOOT, 16'd0);
                    write_reg(eor_pkg::REG_SPMS, 16'd1);
                end
                1: begin
                    write_reg(eor_pkg::REG_OVERSHOOT, 16'hFFFF);
                    write_reg(eor_pkg::REG_SPMS, 16'hFF);
                end
                2: begin
                    write_reg(eor_pkg::REG_OVERSHOOT, 16'h8000);
                    write_reg(eor_pkg::REG_SPMS, 16'd0);
                end
                3: begin
                    write_reg(eor_pkg::REG_OVERSHOOT, 16'h7FFF);
                    write_reg(eor_pkg::REG_SPMS, 16'd192);
                end
                4: begin
                    write_reg(eor_pkg::REG_OVERSHOOT, 16'($urandom));
                    write_reg(eor_pkg::REG_SPMS, 16'($urandom_range(1, 192)));
                end
                default: begin
                    write_reg(eor_pkg::REG_OVERSHOOT, 16'd6554);
                    write_reg(eor_pkg::REG_SPMS, 16'd48);
                end
            endcase
            // Bursts of random length with random gaps between them.
            for (int n = 0; n < RANDOM_ITEMS / 6; ) begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst; k++) begin
                    send_random(phase != 3);
                    n++;
                end
                if ($urandom_range(0, 3) != 0)
                    repeat ($urandom_range(1, 12)) send_idle();
                // Once in a while hold off until everything is back.
                if ($urandom_range(0, 19) == 0) drain();
            end
            drain();
        end

        $display("Covered %0d ticks and %0d result beats over six register settings;",
                 ticks_sent, beats_seen);
        $display("ramping beats observed: %0b, failures: %0d", env_ramping_seen, fail_count);
        if (fail_count == 0 && expected_beats.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== exponential_overshoot_ramp_top.f =====
rtl/core/eor_pkg.sv
rtl/core/eor_mul.sv
rtl/core/eor_div.sv
rtl/core/exponential_overshoot_ramp_top.sv
sim/tb_top.sv
